FILE: design/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and constants of the LPC all-pole synthesis filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

    // field widths
    localparam int COEF_W  = 16;   // Q4.12 coefficient
    localparam int CODE_W  = 16;   // residual code / Q1.15 dequantized value
    localparam int GAIN_W  = 16;   // Q8.8 gain
    localparam int HIST_W  = 24;   // Q9.15 history entry
    localparam int SAMP_W  = 16;   // Q1.15 output sample
    localparam int BD_W    = 5;    // bit depth register
    localparam int IDX_W   = 4;    // coefficient slot field

    // shared multiplier: history (or dequantized code) times coefficient (or gain)
    localparam int MUL_A_W = HIST_W + 1;
    localparam int MUL_B_W = COEF_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // 16 taps of 40-bit products at most
    localparam int ACC_W   = 44;
    localparam int Y_W     = PROD_W - 8;

    // APB
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    // register index, taken from paddr[2]
    localparam logic REG_BIT_DEPTH  = 1'b0;
    localparam logic REG_GAIN_RECIP = 1'b1;

    // request type of an input item
    localparam logic REQ_RESIDUAL = 1'b0;
    localparam logic REQ_COEF     = 1'b1;

    localparam logic [BD_W-1:0]   BD_RESET   = 5'd1;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    localparam logic signed [Y_W-1:0] HIST_MAX = Y_W'(64'sd8388607);
    localparam logic signed [Y_W-1:0] HIST_MIN = Y_W'(-64'sd8388608);
    localparam logic signed [Y_W-1:0] SAMP_MAX = Y_W'(64'sd32767);
    localparam logic signed [Y_W-1:0] SAMP_MIN = Y_W'(-64'sd32768);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAC,
        S_GAIN,
        S_SUM,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: design/lpc_synthesis_filter.sv
// ----------------------------------------------------------------------------
// lpc_synthesis_filter
// All-pole LPC synthesis: dequantize, apply gain, add the prediction from the
// last ORDER outputs, saturate into history and onto the output.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  input     in         i_valid / o_stall     i_req_type, i_coef_index,
//                                             i_coef_value, i_code
//  output    out        o_valid / i_stall     o_sample, o_overflow
//  config    in         APB psel/penable      paddr, pwdata, prdata
//
//  A coefficient write is stored as it is taken. A residual item is worked on by
//  one shared 25x17 multiplier that handles one tap per cycle, then the gain
//  product, then the final add and saturation.
//  Reset clears coefficients, history, pointer and registers to their defaults.
//  The output register is freed while the next item is being worked on; if it
//  is still full when a result is ready, the block waits in its last state.
// ----------------------------------------------------------------------------
`default_nettype none

module lpc_synthesis_filter #(
    parameter int ORDER = 10
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,

    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire                                 i_req_type,
    input  wire  [lsf_pkg::IDX_W-1:0]           i_coef_index,
    input  wire  signed [lsf_pkg::COEF_W-1:0]   i_coef_value,
    input  wire  signed [lsf_pkg::CODE_W-1:0]   i_code,

    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic signed [lsf_pkg::SAMP_W-1:0]   o_sample,
    output logic                                o_overflow,

    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [lsf_pkg::APB_AW-1:0]          paddr,
    input  wire  [lsf_pkg::APB_DW-1:0]          pwdata,
    output logic [lsf_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    import lsf_pkg::*;

    localparam int TAP_W = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(ORDER - 1);

    t_state r_state, n_state;

    logic [BD_W-1:0]   r_bit_depth;
    logic [GAIN_W-1:0] r_gain;

    logic signed [COEF_W-1:0] r_coef [ORDER];
    logic signed [HIST_W-1:0] r_hist [ORDER];
    logic [TAP_W-1:0]         r_ptr;

    logic [TAP_W-1:0]         r_tap;
    logic [TAP_W-1:0]         r_k;
    logic signed [CODE_W-1:0] r_v;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_prod_tap;
    logic signed [ACC_W-1:0]   r_acc;

    logic signed [SAMP_W-1:0]  r_res_sample;
    logic                      r_res_ovf;
    logic                      r_out_valid;
    logic signed [SAMP_W-1:0]  r_out_sample;
    logic                      r_out_ovf;

    logic                      in_acc;
    logic                      out_free;
    logic                      cfg_wr;
    logic [BD_W-1:0]           bd_eff;
    logic [3:0]                up_shift;
    logic signed [CODE_W-1:0]  v_deq;
    logic [TAP_W-1:0]          ptr_prev;
    logic signed [Y_W-1:0]     y;
    logic signed [HIST_W-1:0]  h_sat;
    logic signed [SAMP_W-1:0]  s_sat;
    logic                      ovf;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_BIT_DEPTH:  prdata = APB_DW'(r_bit_depth);
            REG_GAIN_RECIP: prdata = APB_DW'(r_gain);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_depth <= BD_RESET;
            r_gain      <= GAIN_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_BIT_DEPTH)
                r_bit_depth <= pwdata[BD_W-1:0];
            else
                r_gain <= pwdata[GAIN_W-1:0];
        end
    end

    // ---------------- handshakes ----------------
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    // ---------------- dequantize ----------------
    always_comb begin
        priority if (r_bit_depth == '0)
            bd_eff = BD_W'(1);
        else if (r_bit_depth > BD_W'(16))
            bd_eff = BD_W'(16);
        else
            bd_eff = r_bit_depth;
        up_shift = 4'(BD_W'(16) - bd_eff);
        // low bits of the code moved to the top; the sign bit lands at bit 15
        v_deq    = i_code <<< up_shift;
    end

    assign ptr_prev = (r_ptr == '0) ? LAST_TAP : r_ptr - TAP_W'(1);

    // ---------------- shared multiplier ----------------
    always_comb begin
        if (r_state == S_GAIN) begin
            mul_a = MUL_A_W'(r_v);
            mul_b = $signed({1'b0, r_gain});
        end else begin
            mul_a = MUL_A_W'(r_hist[r_k]);
            mul_b = MUL_B_W'(r_coef[r_tap]);
        end
        mul_p = mul_a * mul_b;
    end

    // ---------------- final add and saturation ----------------
    always_comb begin
        y = $signed(r_prod[PROD_W-1:8])
          + Y_W'($signed(r_acc[ACC_W-1:12]));
        ovf = 1'b0;
        priority if (y > HIST_MAX) begin
            h_sat = HIST_MAX[HIST_W-1:0];
            ovf   = 1'b1;
        end else if (y < HIST_MIN) begin
            h_sat = HIST_MIN[HIST_W-1:0];
            ovf   = 1'b1;
        end else begin
            h_sat = y[HIST_W-1:0];
        end
        priority if (y > SAMP_MAX) begin
            s_sat = SAMP_MAX[SAMP_W-1:0];
            ovf   = 1'b1;
        end else if (y < SAMP_MIN) begin
            s_sat = SAMP_MIN[SAMP_W-1:0];
            ovf   = 1'b1;
        end else begin
            s_sat = y[SAMP_W-1:0];
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_req_type == REQ_RESIDUAL))
                    n_state = S_MAC;
            end
            S_MAC: begin
                if (r_tap == LAST_TAP)
                    n_state = S_GAIN;
            end
            S_GAIN: n_state = S_SUM;
            S_SUM:  n_state = S_OUT;
            S_OUT: begin
                if (out_free)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (in_acc) begin
            r_v   <= v_deq;
            r_tap <= '0;
            r_k   <= ptr_prev;
        end else if (r_state == S_MAC) begin
            r_tap <= r_tap + TAP_W'(1);
            r_k   <= (r_k == '0) ? LAST_TAP : r_k - TAP_W'(1);
        end
        if (r_state == S_SUM) begin
            r_res_sample <= s_sat;
            r_res_ovf    <= ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_tap <= 1'b0;
            r_acc      <= '0;
            r_ptr      <= '0;
            for (int i = 0; i < ORDER; i++) begin
                r_coef[i] <= '0;
                r_hist[i] <= '0;
            end
        end else begin
            r_prod_tap <= (r_state == S_MAC);
            if (in_acc)
                r_acc <= '0;
            else if (r_prod_tap)
                r_acc <= r_acc + ACC_W'(r_prod);
            if (in_acc && (i_req_type == REQ_COEF) && (32'(i_coef_index) < ORDER))
                r_coef[i_coef_index[TAP_W-1:0]] <= i_coef_value;
            if (r_state == S_SUM) begin
                r_hist[r_ptr] <= h_sat;
                r_ptr         <= (r_ptr == LAST_TAP) ? '0 : r_ptr + TAP_W'(1);
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_sample <= r_res_sample;
            r_out_ovf    <= r_res_ovf;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_sample   = r_out_sample;
    assign o_overflow = r_out_ovf;

endmodule

`default_nettype wire

FILE: test/tb_lpc_synthesis_filter.sv
// ----------------------------------------------------------------------------
// tb_lpc_synthesis_filter
// Self-checking bench for the LPC all-pole synthesis filter. Coefficient
// writes and residual codes go in over a valid/stall channel, and the
// registers are set over APB. A built-in predictor of the filter produces each
// expected sample and overflow flag, and each result is checked in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lpc_synthesis_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import lsf_pkg::*;

    localparam int ORDER      = 10;
    localparam int SETTLE     = ORDER + 8;
    localparam int IDLE_LIMIT = 3000;

    localparam logic [APB_AW-1:0] ADDR_BIT_DEPTH  = {REG_BIT_DEPTH, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_GAIN_RECIP = {REG_GAIN_RECIP, 2'b00};

    typedef enum logic {RX_FREE, RX_RANDOM} t_rx_mode;

    typedef struct packed {
        logic signed [SAMP_W-1:0] smp;
        logic                     ovf;
    } t_synth_result;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic                      i_req_type = 1'b0;
    logic [IDX_W-1:0]          i_coef_index = '0;
    logic signed [COEF_W-1:0]  i_coef_value = '0;
    logic signed [CODE_W-1:0]  i_code = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic signed [SAMP_W-1:0]  o_sample;
    logic                      o_overflow;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_AW-1:0]         paddr = '0;
    logic [APB_DW-1:0]         pwdata = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    always #2 i_clk = ~i_clk;

    lpc_synthesis_filter #(.ORDER(ORDER)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_req_type   (i_req_type),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_code       (i_code),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample     (o_sample),
        .o_overflow   (o_overflow),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------------
    // Filter predictor state
    // ------------------------------------------------------------------------
    logic [BD_W-1:0]          bd_reg   = BD_RESET;
    logic [GAIN_W-1:0]        gain_reg = GAIN_RESET;
    logic signed [COEF_W-1:0] coef_mem [ORDER];
    logic signed [HIST_W-1:0] hist_mem [ORDER];
    int unsigned              hist_ptr = 0;

    t_synth_result expected_samples [$];
    int            fail_count = 0;

    t_rx_mode rx_mode   = RX_FREE;
    int       hold_req  = 0;
    int       hold_left = 0;
    int       seg_left  = 0;
    int       rx_pick;
    bit       tx_gaps   = 1'b0;
    int       idle_cycles = 0;

    initial begin
        for (int j = 0; j < ORDER; j++) begin
            coef_mem[j] = '0;
            hist_mem[j] = '0;
        end
    end

    task automatic synthesize_expected(input logic req, input logic [IDX_W-1:0] idx,
                                       input logic signed [COEF_W-1:0] cval,
                                       input logic signed [CODE_W-1:0] code_in);
        int unsigned   bd;
        int unsigned   k;
        longint        r, v, e, acc, y, h, s;
        logic          ovf;
        t_synth_result res;
        if (req == REQ_COEF) begin
            if (idx < ORDER)
                coef_mem[idx] = cval;
        end else begin
            bd = bd_reg;
            if (bd < 1) bd = 1;
            if (bd > 16) bd = 16;
            r = (longint'(code_in) <<< (64 - bd)) >>> (64 - bd);
            v = r <<< (16 - bd);
            e = (v * longint'(gain_reg)) >>> 8;
            acc = 0;
            for (int j = 0; j < ORDER; j++) begin
                k = (hist_ptr + ORDER - j - 1) % ORDER;
                acc += longint'(coef_mem[j]) * longint'(hist_mem[k]);
            end
            y = e + (acc >>> 12);
            ovf = 1'b0;
            h = y;
            if (h > 64'sd8388607) begin h = 64'sd8388607; ovf = 1'b1; end
            if (h < -64'sd8388608) begin h = -64'sd8388608; ovf = 1'b1; end
            hist_mem[hist_ptr] = h[HIST_W-1:0];
            hist_ptr = (hist_ptr + 1) % ORDER;
            s = y;
            if (s > 64'sd32767) begin s = 64'sd32767; ovf = 1'b1; end
            if (s < -64'sd32768) begin s = -64'sd32768; ovf = 1'b1; end
            res.smp = s[SAMP_W-1:0];
            res.ovf = ovf;
            expected_samples.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!tx_gaps || p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // Called at a rising edge; returns at a rising edge with valid still high
    // when no gap follows.
    task automatic send_item(input logic req, input logic [IDX_W-1:0] idx,
                             input logic [COEF_W-1:0] cval, input logic [CODE_W-1:0] code_v);
        int gap;
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_coef_index <= idx;
        i_coef_value <= cval;
        i_code       <= code_v;
        do @(posedge i_clk); while (o_stall);
        synthesize_expected(req, idx, cval, code_v);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_residual(input logic [CODE_W-1:0] code_v);
        send_item(REQ_RESIDUAL, IDX_W'($urandom), COEF_W'($urandom), code_v);
    endtask

    task automatic send_coef(input int idx, input int cval);
        send_item(REQ_COEF, IDX_W'(idx), COEF_W'(cval), CODE_W'($urandom));
    endtask

    // stop offering, let every result come back, then let the block settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // APB
    // ------------------------------------------------------------------------
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[2] == REG_BIT_DEPTH)
            bd_reg = data[BD_W-1:0];
        else
            gain_reg = data[GAIN_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_check(input logic [APB_AW-1:0] addr);
        logic [APB_DW-1:0] want;
        want = (addr[2] == REG_BIT_DEPTH) ? APB_DW'(bd_reg) : APB_DW'(gain_reg);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $error("prdata at %0d: expected %0d, got %0d", addr, want, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input int bd, input int gain);
        wait_idle();
        apb_write(ADDR_BIT_DEPTH, APB_DW'(bd));
        apb_write(ADDR_GAIN_RECIP, APB_DW'(gain));
        apb_check(ADDR_BIT_DEPTH);
        apb_check(ADDR_GAIN_RECIP);
    endtask

    // ------------------------------------------------------------------------
    // Output side: check and drive stall
    // ------------------------------------------------------------------------
    task automatic check_sample();
        t_synth_result want;
        if (expected_samples.size() == 0) begin
            $error("sample: expected none, got %0d", o_sample);
            fail_count++;
        end else begin
            want = expected_samples.pop_front();
            if (o_sample !== want.smp) begin
                $error("sample: expected %0d, got %0d", want.smp, o_sample);
                fail_count++;
            end
            if (o_overflow !== want.ovf) begin
                $error("overflow: expected %0d, got %0d", want.ovf, o_overflow);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (o_valid && !i_stall)
            check_sample();
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (seg_left > 0) begin
            seg_left--;
        end else if (rx_mode == RX_FREE) begin
            i_stall <= 1'b0;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 60) begin
                i_stall <= 1'b0;
                seg_left = $urandom_range(0, 7);
            end else if (rx_pick < 95) begin
                i_stall <= 1'b1;
                seg_left = $urandom_range(0, 2);
            end else begin
                i_stall <= 1'b1;
                seg_left = $urandom_range(20, 60);
            end
        end
    end

    // watchdog: cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_lpc_synthesis_filter NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_values();
        apb_check(ADDR_BIT_DEPTH);
        apb_check(ADDR_GAIN_RECIP);
        send_residual(16'h0001);    // one-bit code -1
        send_residual(16'hFFFE);    // low bit clear -> 0
    endtask

    task automatic test_coefficient_slots();
        send_coef(0, 32767);
        send_coef(9, -32768);
        send_coef(10, 1234);        // slots ORDER and above are dropped
        send_coef(15, -1);
        set_config(16, 256);
        send_residual(16'h7FFF);
        send_residual(16'h8000);
        send_residual(16'h0000);
        send_residual(16'h0000);    // history runs into saturation here
        send_residual(16'h0000);
        // unit feedback: next output repeats the newest history entry
        send_coef(0, 4096);
        send_coef(9, 0);
        send_residual(16'h0000);
        send_coef(0, 0);
    endtask

    task automatic test_bit_depth_and_gain();
        set_config(0, 256);         // depth zero acts as one bit
        send_residual(16'h0001);
        set_config(31, 65535);      // depth above 16 acts as 16
        send_residual(16'h7FFF);
        send_residual(16'h8000);
        set_config(8, 0);
        send_residual(16'h00FF);
        set_config(16, 512);        // sample clips, history does not
        send_residual(16'h7FFF);
    endtask

    task automatic load_coefficients(input int span);
        for (int j = 0; j < ORDER; j++)
            send_coef(j, int'($urandom_range(0, 2 * span)) - span);
    endtask

    task automatic test_random_phases();
        int bd_set   [9] = '{16, 8, 1, 0, 31, 12, 4, 16, 0};
        int gain_set [9] = '{256, 256, 65535, 128, 256, 0, 2048, 65535, 0};
        int p;
        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 8) begin
                bd_set[ph]   = $urandom_range(0, 31);
                gain_set[ph] = $urandom_range(0, 65535);
            end
            set_config(bd_set[ph], gain_set[ph]);
            // every third phase runs without any idling
            rx_mode = (ph % 3 == 2) ? RX_FREE : RX_RANDOM;
            tx_gaps = (ph % 3 != 2);
            // mostly stable predictors; a hotter set now and then to drive clipping
            load_coefficients((ph % 4 == 3) ? 3000 : 400);
            for (int n = 0; n < 45; n++) begin
                p = $urandom_range(0, 99);
                if (p < 85)
                    send_residual(CODE_W'($urandom));
                else if (p < 95)
                    send_coef($urandom_range(ORDER, 15), $urandom);
                else
                    send_coef($urandom_range(0, ORDER - 1), int'($urandom_range(0, 800)) - 400);
            end
        end
    endtask

    task automatic test_backpressure();
        set_config(16, 128);
        rx_mode  = RX_FREE;
        tx_gaps  = 1'b0;
        hold_req = 300;
        for (int n = 0; n < 30; n++)
            send_residual(CODE_W'($urandom));
        // pause until everything has drained, then resume with idling
        wait_idle();
        rx_mode = RX_RANDOM;
        tx_gaps = 1'b1;
        for (int n = 0; n < 10; n++)
            send_residual(CODE_W'($urandom));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_coefficient_slots();
        test_bit_depth_and_gain();
        test_random_phases();
        test_backpressure();

        wait_idle();
        if (fail_count == 0)
            $display("tb_lpc_synthesis_filter OK");
        else
            $display("tb_lpc_synthesis_filter NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
